[rtl/brec_pkg.sv]
// Shared types, constants and the cold-offset table for the burst row event classifier.
// No dependencies; every other file of the block uses it by scoped names.
package brec_pkg;

	localparam int CURSOR_BITS   = 32;
	localparam int WORD_BITS     = 16;
	localparam int ROW_WORDS     = 8;
	localparam int IN_DATA_BITS  = WORD_BITS * ROW_WORDS;
	localparam int CFG_DATA_BITS = 31;
	localparam int CFG_IDX_BITS  = 2;

	localparam logic [WORD_BITS-1:0] MARK = 16'haa55;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_STAMP = 2'd1,
		KIND_DUAL  = 2'd2
	} row_kind_t;

	typedef logic [CFG_IDX_BITS-1:0] reg_index_t;
	localparam reg_index_t REG_MAX_SAMPLES = 2'd0;
	localparam reg_index_t REG_DIV_SLOW    = 2'd1;
	localparam reg_index_t REG_DIV_FAST    = 2'd2;

	typedef logic [CURSOR_BITS-1:0] cursor_t;
	typedef logic [ROW_WORDS-1:0][WORD_BITS-1:0] row_t;

	typedef struct packed {
		logic [CFG_DATA_BITS-1:0] max_samples;
		logic [7:0]               div_slow;
		logic [7:0]               div_fast;
	} cfg_t;

	typedef struct packed {
		cursor_t     cursor;
		logic [31:0] accepted_rows;
		cursor_t     last_event;
		logic        have_event;
	} state_t;

	typedef struct packed {
		logic              dropped;
		logic              repeat_event;
		logic              bogus;
		logic              to_fast;
		logic [31:0]       event_sample;
		logic signed [8:0] latency_offset;
		logic [7:0]        rate_phase;
		logic [31:0]       event_count;
		logic [31:0]       cursor_at_row;
	} result_t;

	localparam int RESULT_BITS   = $bits(result_t);
	localparam int OUT_DATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

	function automatic logic signed [3:0] cold_offset(input logic [7:0] div);
		logic signed [3:0] val;
		case (div)
			8'd0:       val = 4'sd0;
			8'd1:       val = -4'sd5;
			8'd2:       val = -4'sd1;
			8'd3:       val = 4'sd0;
			8'd4:       val = 4'sd2;
			8'd5, 8'd6: val = 4'sd1;
			default:    val = 4'sd2;
		endcase
		return val;
	endfunction

endpackage

[rtl/burst_row_event_classifier_core.sv]
// Top level of the burst row event classifier: input row register, decode, result register.
// Depends on brec_pkg, brec_cfg and brec_decode.
//
// Usage:
//   Rows arrive on the s_ channel, one row of eight 16-bit words per transaction,
//   word 0 in s_tdata[15:0]. Each row yields exactly one result on the m_ channel:
//   the row kind on m_tuser and the computed fields packed in m_tdata.
//   Registers are written on the cfg_ channel (index 0 sample limit, 1 slow divisor,
//   2 fast divisor); cfg_ready is always high and writes to other indexes do nothing.
// Pipeline and throughput:
//   Each row is held in the row register, then decoded into the result register on m_.
//   One row per cycle is sustained while m_tready is high; each register holds one row,
//   and the sample cursor and event history update in the same cycle as the decode.
// Reset:
//   arst_n clears both stages, the cursor, the row count, the event history and the
//   registers (sample limit to all ones, divisors to zero).
// Stall:
//   While m_tready is low the result holds; one more row is taken into the row
//   register, after which s_tready drops until the result is taken.
module burst_row_event_classifier_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// word_0 .. word_7, 16 bits each, word_0 lowest
	input  logic [brec_pkg::IN_DATA_BITS-1:0]    s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// cursor_at_row[31:0], event_count[63:32], rate_phase[71:64],
	// latency_offset[80:72], event_sample[112:81], to_fast[113], bogus[114],
	// repeat_event[115], dropped[116], zero fill[119:117]
	output logic [brec_pkg::OUT_DATA_BITS-1:0]   m_tdata,
	// row_kind[1:0]
	output logic [1:0]                           m_tuser,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  brec_pkg::reg_index_t                 cfg_index,
	input  logic [brec_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	brec_pkg::cfg_t      cfg;
	brec_pkg::state_t    state_q;
	brec_pkg::state_t    state_next;
	brec_pkg::row_t      row_s1;
	logic                valid_s1;
	logic                s_acc;
	logic                move;
	brec_pkg::row_kind_t kind;
	brec_pkg::result_t   res;
	brec_pkg::row_kind_t kind_q;
	brec_pkg::result_t   res_q;
	logic                m_valid_q;

	assign cfg_ready = 1'b1;

	brec_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	brec_decode u_decode (
		.row        (row_s1),
		.cfg        (cfg),
		.state      (state_q),
		.kind       (kind),
		.res        (res),
		.state_next (state_next)
	);

	assign move     = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || !m_valid_q || m_tready;
	assign s_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
			state_q   <= '0;
		end else begin
			if (s_acc) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				m_valid_q <= 1'b1;
				state_q   <= state_next;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			row_s1 <= s_tdata;
		end
		if (move) begin
			kind_q <= kind;
			res_q  <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(brec_pkg::OUT_DATA_BITS - brec_pkg::RESULT_BITS)'(0), res_q};
	assign m_tuser  = kind_q;

endmodule

[rtl/brec_cfg.sv]
// Configuration register file: sample limit and the two divisor registers.
// Depends on brec_pkg.
module brec_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  brec_pkg::reg_index_t                wr_index,
	input  logic [brec_pkg::CFG_DATA_BITS-1:0]  wr_data,
	output brec_pkg::cfg_t                      cfg
);

	brec_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_samples <= '1;
			cfg_q.div_slow    <= '0;
			cfg_q.div_fast    <= '0;
		end else if (wr_en) begin
			case (wr_index)
				brec_pkg::REG_MAX_SAMPLES: cfg_q.max_samples <= wr_data;
				brec_pkg::REG_DIV_SLOW:    cfg_q.div_slow    <= wr_data[7:0];
				brec_pkg::REG_DIV_FAST:    cfg_q.div_fast    <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/brec_decode.sv]
// Row classification and result computation for one registered row.
// Depends on brec_pkg; purely combinational.
module brec_decode (
	input  brec_pkg::row_t      row,
	input  brec_pkg::cfg_t      cfg,
	input  brec_pkg::state_t    state,
	output brec_pkg::row_kind_t kind,
	output brec_pkg::result_t   res,
	output brec_pkg::state_t    state_next
);

	localparam int CB = brec_pkg::CURSOR_BITS;

	logic                is_stamp;
	logic                is_dual;
	logic                rep;
	logic                b0;
	logic                b1;
	logic [7:0]          div;
	logic signed [3:0]   co;
	logic signed [8:0]   off;
	logic [8:0]          off_mag;
	logic [CB:0]         diff;
	logic [CB:0]         sum;
	brec_pkg::cursor_t   samp;
	brec_pkg::cursor_t   cur;

	assign cur = state.cursor;

	assign is_stamp = (row[0] == brec_pkg::MARK) && (row[1] == brec_pkg::MARK) &&
	                  (row[2] == brec_pkg::MARK) && (row[3] == brec_pkg::MARK);
	assign is_dual  = !is_stamp &&
	                  (row[0] == brec_pkg::MARK) && (row[1] == brec_pkg::MARK) &&
	                  (row[4] == brec_pkg::MARK) && (row[5] == brec_pkg::MARK);

	assign b0  = row[3][0];
	assign b1  = row[3][1];
	assign div = b1 ? cfg.div_fast : cfg.div_slow;
	assign co  = brec_pkg::cold_offset(div);
	assign off = $signed({3'b000, row[2][7:2]}) + $signed({{5{co[3]}}, co});
	assign off_mag = off[8] ? 9'(-off) : 9'(off);

	assign diff = {1'b0, cur} - (CB+1)'(off_mag);
	assign sum  = {1'b0, cur} + (CB+1)'(off_mag);

	always_comb begin
		if (off[8]) begin
			samp = sum[CB] ? '1 : sum[CB-1:0];
		end else begin
			samp = diff[CB] ? '0 : diff[CB-1:0];
		end
	end

	assign rep = state.have_event && (state.last_event == cur);

	always_comb begin
		state_next         = state;
		res                = '0;
		res.cursor_at_row  = 32'(cur);
		kind               = brec_pkg::KIND_DATA;
		if (is_stamp || is_dual) begin
			res.repeat_event = rep;
			if (!rep) begin
				state_next.have_event = 1'b1;
				state_next.last_event = cur;
			end
			if (is_stamp) begin
				kind            = brec_pkg::KIND_STAMP;
				res.event_count = {row[4], row[6]};
			end else begin
				kind               = brec_pkg::KIND_DUAL;
				res.rate_phase     = row[2][15:8];
				res.latency_offset = off;
				res.event_sample   = 32'(samp);
				res.to_fast        = b1;
				res.bogus          = (b0 == b1);
			end
		end else if (state.accepted_rows < {1'b0, cfg.max_samples}) begin
			state_next.accepted_rows = state.accepted_rows + 32'd1;
			state_next.cursor        = cur + CB'(1);
		end else begin
			res.dropped = 1'b1;
		end
	end

endmodule

[rtl/brec_checker.sv]
// Port-level checks for burst_row_event_classifier_core, attached by bind.
// Depends on brec_pkg and the top level's ports.
module brec_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [brec_pkg::OUT_DATA_BITS-1:0]  m_tdata,
	input logic [1:0]                          m_tuser
);

	brec_pkg::result_t res;
	logic              m_acc;
	logic              s_acc;

	assign res   = m_tdata[brec_pkg::RESULT_BITS-1:0];
	assign m_acc = m_tvalid && m_tready;
	assign s_acc = s_tvalid && s_tready;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("result changed while stalled");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result valid during reset");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_acc, 2))
		else $error("result appeared without a row two cycles before");

	a_cursor_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_acc && (m_tuser == brec_pkg::KIND_DATA) && !res.dropped) ##1 m_acc
		|-> (res.cursor_at_row == $past(res.cursor_at_row) + 32'd1))
		else $error("cursor did not advance after a kept data row");

endmodule

bind burst_row_event_classifier_core brec_checker u_brec_checker (.*);
